### rtl/ihs_pkg.sv
`default_nettype none

package ihs_pkg;

  // Scan window for the JPEG marker walk, in bytes
  localparam int unsigned WINDOW_BYTES = 2048;
  localparam logic [16:0] WIN_LIMIT    = 17'(WINDOW_BYTES - 10);

  // Fixed-offset header bytes kept for PNG, GIF and BMP
  localparam int unsigned HDR_BYTES = 30;
  localparam logic [15:0] HDR_LAST  = 16'(HDR_BYTES - 1);

  localparam logic [2:0] FMT_UNKNOWN = 3'd0;
  localparam logic [2:0] FMT_PNG     = 3'd1;
  localparam logic [2:0] FMT_GIF     = 3'd2;
  localparam logic [2:0] FMT_BMP     = 3'd3;
  localparam logic [2:0] FMT_JPEG    = 3'd4;

  // Signature bytes
  localparam logic [7:0] PNG_SIG0 = 8'd137;
  localparam logic [7:0] PNG_SIG1 = 8'd80;
  localparam logic [7:0] PNG_SIG2 = 8'd78;
  localparam logic [7:0] GIF_SIG0 = 8'd71;
  localparam logic [7:0] GIF_SIG1 = 8'd73;
  localparam logic [7:0] GIF_SIG2 = 8'd70;
  localparam logic [7:0] BMP_SIG0 = 8'd66;
  localparam logic [7:0] BMP_SIG1 = 8'd77;

  // PNG color types
  localparam logic [7:0] PNG_GREY       = 8'd0;
  localparam logic [7:0] PNG_RGB        = 8'd2;
  localparam logic [7:0] PNG_PALETTE    = 8'd3;
  localparam logic [7:0] PNG_GREY_ALPHA = 8'd4;
  localparam logic [7:0] PNG_RGBA       = 8'd6;

  // JPEG marker bytes
  localparam logic [7:0] JPG_FF  = 8'hFF;
  localparam logic [7:0] JPG_SOI = 8'hD8;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  image_format;
    logic [15:0] image_width;
    logic [15:0] img_height;
    logic [10:0] bits_per_pixel;
  } out_t;

  typedef enum logic [7:0] {
    PH_SEEK_START = 8'b0000_0001,
    PH_SEEK_FF    = 8'b0000_0010,
    PH_MARKER     = 8'b0000_0100,
    PH_LEN_HI     = 8'b0000_1000,
    PH_LEN_LO     = 8'b0001_0000,
    PH_FRAME      = 8'b0010_0000,
    PH_SKIP       = 8'b0100_0000,
    PH_FOUND      = 8'b1000_0000
  } jpeg_phase_t;

  // Walker status, as it stands after the current byte
  typedef struct packed {
    logic        found;
    logic        in_frame;
    logic [15:0] width;
    logic [15:0] height;
    logic [10:0] bpp;
  } jpeg_status_t;

  function automatic logic is_sof(input logic [7:0] m);
    return m inside {[8'hC0:8'hC3], [8'hC5:8'hC7], [8'hC9:8'hCB], [8'hCD:8'hCF]};
  endfunction

  // Standalone markers: no length field follows
  function automatic logic is_bare_marker(input logic [7:0] m);
    return m inside {8'h00, 8'h01, [8'hD0:8'hD8]};
  endfunction

endpackage

`default_nettype wire

### rtl/image_header_sniffer.sv
// A result enters the output register in the cycle after the byte that decides it. One
// byte per cycle unless stalled; the output register frees up in the cycle it is taken.
// Format decode and the JPEG marker walk both settle in one pass of logic per byte.
// Reset (rst, synchronous) clears position, walker state and the answered flag;
// a byte with last_byte set re-arms the same way for the next file.
// Header bytes not yet received in the current file read as zero.
`default_nettype none

module image_header_sniffer import ihs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  logic         in_fire;
  logic         step;
  logic         rearm;
  logic         judge;
  logic         emit;
  logic         ok;
  logic [15:0]  byte_position;
  logic         answer_given;
  logic [7:0]   header_store [HDR_BYTES];
  logic [7:0]   hdr [HDR_BYTES];
  jpeg_status_t jstat;
  out_t         res;
  logic         fixed_hit;
  logic [7:0]   d;

  // A new request goes in whenever the output register is empty or being drained
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  // Bytes after the answer are ignored until the last one
  assign step     = in_fire && !answer_given;
  assign rearm    = in_fire && in_data.last_byte;
  assign ok       = {1'b0, byte_position} < WIN_LIMIT;

  // Current view of the header: stored bytes, the byte arriving now, zero beyond
  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      if (byte_position > 16'(i)) hdr[i] = header_store[i];
      else if (byte_position == 16'(i)) hdr[i] = in_data.byte_value;
      else hdr[i] = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (step && byte_position < 16'(HDR_BYTES))
      header_store[byte_position[4:0]] <= in_data.byte_value;
  end

  ihs_jpeg_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rearm     (rearm),
    .ok        (ok),
    .byte_value(in_data.byte_value),
    .status    (jstat)
  );

  // Fixed-offset formats, then JPEG, then give-up
  assign d = hdr[24];
  always_comb begin
    res       = '0;
    fixed_hit = 1'b0;
    if (hdr[0] == PNG_SIG0 && hdr[1] == PNG_SIG1 && hdr[2] == PNG_SIG2) begin
      // unknown color type falls through to the JPEG result
      fixed_hit           = 1'b1;
      res.image_format    = FMT_PNG;
      res.image_width     = {hdr[18], hdr[19]};
      res.img_height      = {hdr[22], hdr[23]};
      case (hdr[25])
        PNG_GREY:       res.bits_per_pixel = 11'(d);
        PNG_RGB:        res.bits_per_pixel = 11'({d, 1'b0}) + 11'(d);
        PNG_PALETTE:    res.bits_per_pixel = 11'd8;
        PNG_GREY_ALPHA: res.bits_per_pixel = 11'({d, 1'b0});
        PNG_RGBA:       res.bits_per_pixel = 11'({d, 2'b00});
        default: begin
          fixed_hit = 1'b0;
          res       = '0;
        end
      endcase
    end else if (hdr[0] == GIF_SIG0 && hdr[1] == GIF_SIG1 && hdr[2] == GIF_SIG2) begin
      fixed_hit          = 1'b1;
      res.image_format   = FMT_GIF;
      res.image_width    = {hdr[7], hdr[6]};
      res.img_height     = {hdr[9], hdr[8]};
      res.bits_per_pixel = 11'(hdr[10][2:0]) + 11'd1;
    end else if (hdr[0] == BMP_SIG0 && hdr[1] == BMP_SIG1) begin
      fixed_hit          = 1'b1;
      res.image_format   = FMT_BMP;
      res.image_width    = {hdr[19], hdr[18]};
      res.img_height     = {hdr[23], hdr[22]};
      res.bits_per_pixel = 11'(hdr[28]);
    end
    if (!fixed_hit && jstat.found) begin
      res.image_format   = FMT_JPEG;
      res.image_width    = jstat.width;
      res.img_height     = jstat.height;
      res.bits_per_pixel = jstat.bpp;
    end
  end

  // Judged from the last fixed header byte on, or at end of file
  assign judge = step && (byte_position >= HDR_LAST || in_data.last_byte);
  assign emit  = judge && (fixed_hit || jstat.found || in_data.last_byte ||
                           (!ok && !jstat.in_frame));

  always_ff @(posedge clk) begin
    if (rst || rearm) begin
      byte_position <= 16'd0;
      answer_given  <= 1'b0;
    end else begin
      if (step && byte_position != 16'hFFFF) byte_position <= byte_position + 16'd1;
      if (emit) answer_given <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) out_data <= res;
  end

  a_rearm_clears: assert property (@(posedge clk) disable iff (rst)
    rearm |=> byte_position == 16'd0 && !answer_given)
    else $error("last byte did not re-arm the sniffer");

  a_one_answer: assert property (@(posedge clk) disable iff (rst)
    emit && !rearm |=> answer_given)
    else $error("answer not recorded after result");

  a_fmt_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.image_format <= FMT_JPEG)
    else $error("format code out of range");

  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.image_format == FMT_UNKNOWN |->
      out_data.image_width == 16'd0 && out_data.img_height == 16'd0 &&
      out_data.bits_per_pixel == 11'd0)
    else $error("unknown format carries nonzero fields");

endmodule

`default_nettype wire

### rtl/ihs_jpeg_walk.sv
`default_nettype none

module ihs_jpeg_walk import ihs_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire logic         rearm,
  input  wire logic         ok,
  input  wire logic [7:0]   byte_value,
  output jpeg_status_t      status
);

  jpeg_phase_t phase, phase_next;
  logic [1:0]  match, match_next;
  logic [15:0] skip, skip_next;
  logic [3:0]  idx, idx_next;
  logic [7:0]  ff [5];
  logic [7:0]  ff_next [5];
  logic [15:0] seg_len;
  logic [2:0]  fidx;

  assign seg_len = {skip[15:8], byte_value};
  assign fidx    = 3'(idx - 4'd3);

  always_comb begin
    phase_next = phase;
    match_next = match;
    skip_next  = skip;
    idx_next   = idx;
    ff_next    = ff;
    unique case (phase)
      PH_SEEK_START: begin
        if (ok) begin
          case (match)
            2'd0: begin
              if (byte_value == JPG_FF) match_next = 2'd1;
            end
            2'd1: begin
              if (byte_value == JPG_SOI) match_next = 2'd2;
              else if (byte_value != JPG_FF) match_next = 2'd0;
            end
            default: begin
              match_next = 2'd0;
              if (byte_value == JPG_FF) phase_next = PH_MARKER;
            end
          endcase
        end
      end
      PH_SEEK_FF: begin
        if (ok && byte_value == JPG_FF) phase_next = PH_MARKER;
      end
      PH_MARKER: begin
        if (ok && byte_value != JPG_FF) begin
          if (is_bare_marker(byte_value)) begin
            phase_next = PH_SEEK_FF;
          end else if (is_sof(byte_value)) begin
            phase_next = PH_FRAME;
            idx_next   = 4'd0;
          end else begin
            phase_next = PH_LEN_HI;
          end
        end
      end
      PH_LEN_HI: begin
        skip_next  = {byte_value, 8'h00};
        phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (seg_len <= 16'd2) begin
          skip_next  = 16'd0;
          phase_next = PH_SEEK_FF;
        end else begin
          skip_next  = seg_len - 16'd2;
          phase_next = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_next = skip - 16'd1;
        if (skip == 16'd1) phase_next = PH_SEEK_FF;
      end
      PH_FRAME: begin
        // frame header: P, Yhi, Ylo, Xhi, Xlo, Nf after the length
        if (idx >= 4'd3 && idx <= 4'd7) ff_next[fidx] = byte_value;
        if (idx >= 4'd7) phase_next = PH_FOUND;
        else idx_next = idx + 4'd1;
      end
      PH_FOUND: begin
      end
      default: begin
        phase_next = PH_SEEK_START;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || rearm) begin
      phase <= PH_SEEK_START;
      match <= 2'd0;
      skip  <= 16'd0;
      idx   <= 4'd0;
    end else if (step) begin
      phase <= phase_next;
      match <= match_next;
      skip  <= skip_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) ff <= ff_next;
  end

  always_comb begin
    status.found    = (phase_next == PH_FOUND);
    status.in_frame = (phase_next == PH_FRAME);
    status.width    = {ff_next[2], ff_next[3]};
    status.height   = {ff_next[0], ff_next[1]};
    status.bpp      = {ff_next[4], 3'b000};
  end

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> skip != 16'd0)
    else $error("segment skip count zero while skipping");

  a_frame_idx: assert property (@(posedge clk) disable iff (rst)
    phase == PH_FRAME |-> idx <= 4'd7)
    else $error("frame field index ran past header");

  a_found_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_FOUND && !rearm |=> phase == PH_FOUND)
    else $error("walker left found state without re-arm");

endmodule

`default_nettype wire
